// ===== hdl/ecp_pkg.sv =====
`timescale 1ns / 1ps

package ecp_pkg;

    localparam int VEC_FRAC_BITS  = 14;
    localparam int TRIG_FRAC_BITS = 30;
    localparam int CORDIC_STEPS   = 30;

    localparam logic [15:0] TURN    = 16'd46080;
    localparam logic [15:0] QUARTER = 16'd11520;
    localparam logic signed [14:0] PITCH_MAX = 15'sd11392;
    localparam logic signed [14:0] PITCH_MIN = -15'sd11392;

    localparam logic [1:0] MODE_ROT   = 2'd0;
    localparam logic [1:0] MODE_FLY   = 2'd1;
    localparam logic [1:0] MODE_WALK  = 2'd2;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    localparam logic [2:0] CFG_START_X     = 3'd0;
    localparam logic [2:0] CFG_START_Y     = 3'd1;
    localparam logic [2:0] CFG_START_Z     = 3'd2;
    localparam logic [2:0] CFG_START_YAW   = 3'd3;
    localparam logic [2:0] CFG_START_PITCH = 3'd4;

    typedef struct packed {
        logic [1:0]          mode;
        logic signed [15:0]  delta_yaw;
        logic signed [15:0]  delta_pitch;
        logic signed [23:0]  move_x;
        logic signed [23:0]  move_y;
        logic signed [23:0]  move_z;
    } cam_in_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] fwd_x;
        logic signed [15:0] fwd_y;
        logic signed [15:0] fwd_z;
        logic signed [15:0] rgt_x;
        logic signed [15:0] rgt_y;
        logic signed [15:0] rgt_z;
        logic signed [15:0] upv_x;
        logic signed [15:0] upv_y;
        logic signed [15:0] upv_z;
    } cam_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_LOAD,
        ST_ANGLE,
        ST_YAW_INIT,
        ST_YAW_ITER,
        ST_YAW_FIN,
        ST_PIT_INIT,
        ST_PIT_ITER,
        ST_PIT_FIN,
        ST_AXES,
        ST_FLY,
        ST_WALK,
        ST_OUT
    } ctrl_state_t;

    typedef enum logic [3:0] {
        MS_CY_CP,
        MS_SY_CP,
        MS_CY_SP,
        MS_SY_SP,
        MS_RGT_MX,
        MS_UPV_MY,
        MS_FWD_MZ,
        MS_CY_MX,
        MS_SY_MZ,
        MS_CY_MZ,
        MS_SY_MX
    } mul_sel_t;

    typedef enum logic [1:0] {
        PS_ACC_VEC,
        PS_ACC_TRIG,
        PS_MOVE_Y
    } pos_src_t;

    typedef struct packed {
        logic       latch;
        logic       load;
        logic       angle;
        logic       cinit;
        logic       citer;
        logic       cfin;
        logic       csel_pitch;
        logic [4:0] idx;
        logic       mul_en;
        mul_sel_t   sel;
        logic       acc_en;
        logic       acc_clr;
        logic       acc_sub;
        logic       ax_wr;
        logic [1:0] ax_idx;
        logic       pos_wr;
        pos_src_t   src;
        logic [1:0] k;
        logic       out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic       loaded;
        logic [1:0] mode;
        logic       moving;
    } dp_status_t;

    // arctangent of 2^-i in Q30 radians
    function automatic logic signed [32:0] atan_q30(input logic [4:0] i);
        logic signed [32:0] v;
        unique case (i)
            5'd0:  v = 33'sh03243F6A8;
            5'd1:  v = 33'sh01DAC6705;
            5'd2:  v = 33'sh00FADBAFC;
            5'd3:  v = 33'sh007F56EA6;
            5'd4:  v = 33'sh003FEAB76;
            5'd5:  v = 33'sh001FFD55B;
            5'd6:  v = 33'sh000FFFAAA;
            5'd7:  v = 33'sh0007FFF55;
            5'd8:  v = 33'sh0003FFFEA;
            5'd9:  v = 33'sh0001FFFFD;
            5'd10: v = 33'sh0000FFFFF;
            5'd11: v = 33'sh00007FFFF;
            5'd12: v = 33'sh00003FFFF;
            5'd13: v = 33'sh00001FFFF;
            5'd14: v = 33'sh00000FFFF;
            5'd15: v = 33'sh000007FFF;
            5'd16: v = 33'sh000003FFF;
            5'd17: v = 33'sh000001FFF;
            5'd18: v = 33'sh000000FFF;
            5'd19: v = 33'sh0000007FF;
            5'd20: v = 33'sh0000003FF;
            5'd21: v = 33'sh0000001FF;
            5'd22: v = 33'sh0000000FF;
            5'd23: v = 33'sh00000007F;
            5'd24: v = 33'sh00000003F;
            5'd25: v = 33'sh00000001F;
            5'd26: v = 33'sh00000000F;
            5'd27: v = 33'sh000000008;
            5'd28: v = 33'sh000000004;
            5'd29: v = 33'sh000000002;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/ecp_ctrl.sv =====
`timescale 1ns / 1ps

module ecp_ctrl import ecp_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg, state_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [1:0]  k_reg, k_next;
    logic        after_load_reg, after_load_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            k_reg          <= '0;
            after_load_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            k_reg          <= k_next;
            after_load_reg <= after_load_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        k_next          = k_reg;
        after_load_next = after_load_reg;
        out_valid_next  = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                cnt_next = '0;
                k_next   = '0;
                priority if (!status.loaded)
                    state_next = ST_LOAD;
                else if (status.mode == MODE_ROT)
                    state_next = ST_ANGLE;
                else if (status.mode == MODE_FLY && status.moving)
                    state_next = ST_FLY;
                else if (status.mode == MODE_WALK && status.moving)
                    state_next = ST_WALK;
                else
                    state_next = ST_OUT;
            end
            ST_LOAD:
            begin
                after_load_next = 1'b1;
                state_next      = ST_YAW_INIT;
            end
            ST_ANGLE:
            begin
                state_next = ST_YAW_INIT;
            end
            ST_YAW_INIT:
            begin
                cnt_next   = '0;
                state_next = ST_YAW_ITER;
            end
            ST_YAW_ITER:
            begin
                if (cnt_reg == 5'(CORDIC_STEPS - 1))
                    state_next = ST_YAW_FIN;
                else
                    cnt_next = cnt_reg + 5'd1;
            end
            ST_YAW_FIN:
            begin
                state_next = ST_PIT_INIT;
            end
            ST_PIT_INIT:
            begin
                cnt_next   = '0;
                state_next = ST_PIT_ITER;
            end
            ST_PIT_ITER:
            begin
                if (cnt_reg == 5'(CORDIC_STEPS - 1))
                    state_next = ST_PIT_FIN;
                else
                    cnt_next = cnt_reg + 5'd1;
            end
            ST_PIT_FIN:
            begin
                cnt_next   = '0;
                state_next = ST_AXES;
            end
            ST_AXES:
            begin
                if (cnt_reg == 5'd7)
                begin
                    after_load_next = 1'b0;
                    state_next      = after_load_reg ? ST_DISPATCH : ST_OUT;
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            ST_FLY:
            begin
                if (cnt_reg == 5'd4)
                begin
                    cnt_next = '0;
                    if (k_reg == 2'd2)
                        state_next = ST_OUT;
                    else
                        k_next = k_reg + 2'd1;
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            ST_WALK:
            begin
                priority if (k_reg == 2'd1)
                begin
                    k_next   = 2'd2;
                    cnt_next = '0;
                end
                else if (cnt_reg == 5'd3)
                begin
                    cnt_next = '0;
                    if (k_reg == 2'd2)
                        state_next = ST_OUT;
                    else
                        k_next = 2'd1;
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath commands
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:     cmd.latch = in_valid;
            ST_DISPATCH: ;
            ST_LOAD:     cmd.load = 1'b1;
            ST_ANGLE:    cmd.angle = 1'b1;
            ST_YAW_INIT: cmd.cinit = 1'b1;
            ST_YAW_ITER:
            begin
                cmd.citer = 1'b1;
                cmd.idx   = cnt_reg;
            end
            ST_YAW_FIN:  cmd.cfin = 1'b1;
            ST_PIT_INIT:
            begin
                cmd.cinit      = 1'b1;
                cmd.csel_pitch = 1'b1;
            end
            ST_PIT_ITER:
            begin
                cmd.citer      = 1'b1;
                cmd.csel_pitch = 1'b1;
                cmd.idx        = cnt_reg;
            end
            ST_PIT_FIN:
            begin
                cmd.cfin       = 1'b1;
                cmd.csel_pitch = 1'b1;
            end
            ST_AXES:
            begin
                // even cycles multiply, odd cycles round and store
                if (!cnt_reg[0])
                begin
                    cmd.mul_en = 1'b1;
                    unique case (cnt_reg[2:1])
                        2'd0: cmd.sel = MS_CY_CP;
                        2'd1: cmd.sel = MS_SY_CP;
                        2'd2: cmd.sel = MS_CY_SP;
                        default: cmd.sel = MS_SY_SP;
                    endcase
                end
                else
                begin
                    cmd.ax_wr  = 1'b1;
                    cmd.ax_idx = cnt_reg[2:1];
                end
            end
            ST_FLY:
            begin
                cmd.k       = k_reg;
                cmd.src     = PS_ACC_VEC;
                cmd.mul_en  = (cnt_reg <= 5'd2);
                cmd.acc_en  = (cnt_reg >= 5'd1) && (cnt_reg <= 5'd3);
                cmd.acc_clr = (cnt_reg == 5'd1);
                cmd.pos_wr  = (cnt_reg == 5'd4);
                unique case (cnt_reg[1:0])
                    2'd0: cmd.sel = MS_RGT_MX;
                    2'd1: cmd.sel = MS_UPV_MY;
                    default: cmd.sel = MS_FWD_MZ;
                endcase
            end
            ST_WALK:
            begin
                cmd.k = k_reg;
                if (k_reg == 2'd1)
                begin
                    cmd.pos_wr = 1'b1;
                    cmd.src    = PS_MOVE_Y;
                end
                else
                begin
                    cmd.src     = PS_ACC_TRIG;
                    cmd.mul_en  = (cnt_reg <= 5'd1);
                    cmd.acc_en  = (cnt_reg == 5'd1) || (cnt_reg == 5'd2);
                    cmd.acc_clr = (cnt_reg == 5'd1);
                    cmd.acc_sub = (k_reg == 2'd2) && (cnt_reg == 5'd2);
                    cmd.pos_wr  = (cnt_reg == 5'd3);
                    if (k_reg == 2'd0)
                        cmd.sel = cnt_reg[0] ? MS_SY_MZ : MS_CY_MX;
                    else
                        cmd.sel = cnt_reg[0] ? MS_SY_MX : MS_CY_MZ;
                end
            end
            ST_OUT:      cmd.out_load = out_free;
            default:     ;
        endcase
    end

endmodule

// ===== hdl/ecp_datapath.sv =====
`timescale 1ns / 1ps

module ecp_datapath import ecp_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  cam_in_t     in_item,
    input  dp_cmd_t     cmd,
    output dp_status_t  status,
    output cam_out_t    out_item
);

    localparam logic signed [17:0] TURN_S   = 18'sd46080;
    localparam logic signed [16:0] TURN_P   = 17'sd46080;
    localparam logic signed [32:0] ONE_Q30  = 33'sh040000000;
    localparam logic signed [32:0] CX_INIT  = 33'sh026DD3B6A;
    localparam logic signed [33:0] SUM_MAX  = 34'sd2147483647;
    localparam logic signed [33:0] SUM_MIN  = -34'sd2147483648;
    localparam int SH_TRIG = TRIG_FRAC_BITS - VEC_FRAC_BITS;
    localparam int SH_PROD = 2 * TRIG_FRAC_BITS - VEC_FRAC_BITS;

    function automatic logic signed [15:0] rnd_trig(input logic signed [32:0] v);
        logic signed [32:0] t;
        t = v + (33'sd1 <<< (SH_TRIG - 1));
        return 16'(t >>> SH_TRIG);
    endfunction

    function automatic logic signed [15:0] rnd_prod(input logic signed [63:0] v);
        logic signed [63:0] t;
        t = v + (64'sd1 <<< (SH_PROD - 1));
        return 16'(t >>> SH_PROD);
    endfunction

    // start pose registers
    logic signed [31:0] start_x_reg, start_y_reg, start_z_reg;
    logic [15:0]        start_yaw_reg;
    logic signed [14:0] start_pitch_reg;

    cam_in_t            in_reg;
    logic               loaded_reg;
    logic signed [31:0] pos_reg [0:2];
    logic [15:0]        yaw_reg;
    logic signed [14:0] pitch_reg;
    logic signed [15:0] fwd_reg [0:2];
    logic signed [15:0] rgt_reg [0:2];
    logic signed [15:0] upv_reg [0:2];
    logic signed [31:0] sy_reg, cy_reg, sp_reg, cp_reg;
    logic signed [32:0] cor_x_reg, cor_y_reg, cor_z_reg;
    logic [1:0]         quad_reg;
    logic signed [63:0] prod_reg, acc_reg;
    cam_out_t           out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg     <= '0;
            start_y_reg     <= '0;
            start_z_reg     <= '0;
            start_yaw_reg   <= '0;
            start_pitch_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_START_X:     start_x_reg     <= cfg_data;
                CFG_START_Y:     start_y_reg     <= cfg_data;
                CFG_START_Z:     start_z_reg     <= cfg_data;
                CFG_START_YAW:   start_yaw_reg   <= cfg_data[15:0];
                CFG_START_PITCH: start_pitch_reg <= cfg_data[14:0];
                default:         ;
            endcase
        end
    end

    // start pose reduction
    logic [15:0]        start_yaw_red;
    logic signed [14:0] start_pitch_cl;

    always_comb
    begin
        start_yaw_red = (start_yaw_reg >= TURN) ? start_yaw_reg - TURN : start_yaw_reg;
        priority if (start_pitch_reg > PITCH_MAX)
            start_pitch_cl = PITCH_MAX;
        else if (start_pitch_reg < PITCH_MIN)
            start_pitch_cl = PITCH_MIN;
        else
            start_pitch_cl = start_pitch_reg;
    end

    // angle update
    logic signed [17:0] yaw_sum;
    logic signed [16:0] pitch_sum;
    logic [15:0]        yaw_new;
    logic signed [14:0] pitch_new;

    always_comb
    begin
        yaw_sum   = $signed({2'b00, yaw_reg}) + 18'(in_reg.delta_yaw);
        pitch_sum = 17'(pitch_reg) + 17'(in_reg.delta_pitch);
        priority if (yaw_sum < 0)
            yaw_new = 16'(yaw_sum + TURN_S);
        else if (yaw_sum >= TURN_S)
            yaw_new = 16'(yaw_sum - TURN_S);
        else
            yaw_new = 16'(yaw_sum);
        priority if (pitch_sum > 17'(PITCH_MAX))
            pitch_new = PITCH_MAX;
        else if (pitch_sum < 17'(PITCH_MIN))
            pitch_new = PITCH_MIN;
        else
            pitch_new = 15'(pitch_sum);
    end

    // CORDIC setup: quadrant and Q30 radians
    logic signed [16:0] pitch_ext, pitch_ang;
    logic [15:0]        ang;
    logic [1:0]         quad;
    logic [15:0]        rem;
    logic [37:0]        z_scaled;

    always_comb
    begin
        pitch_ext = 17'(pitch_reg);
        pitch_ang = (pitch_ext < 0) ? pitch_ext + TURN_P : pitch_ext;
        ang       = cmd.csel_pitch ? 16'(pitch_ang) : yaw_reg;
        priority if (ang >= 16'd34560)
        begin
            quad = 2'd3;
            rem  = ang - 16'd34560;
        end
        else if (ang >= 16'd23040)
        begin
            quad = 2'd2;
            rem  = ang - 16'd23040;
        end
        else if (ang >= QUARTER)
        begin
            quad = 2'd1;
            rem  = ang - QUARTER;
        end
        else
        begin
            quad = 2'd0;
            rem  = ang;
        end
        z_scaled = (38'(rem[13:0]) * 38'd9370165 + 38'd32) >> 6;
    end

    // CORDIC step and finish
    logic signed [32:0] sh_x, sh_y, atan_i;
    logic signed [32:0] x_cl, y_cl;
    logic signed [31:0] sn, cs;

    always_comb
    begin
        sh_x   = cor_x_reg >>> cmd.idx;
        sh_y   = cor_y_reg >>> cmd.idx;
        atan_i = atan_q30(cmd.idx);
        priority if (cor_x_reg > ONE_Q30)
            x_cl = ONE_Q30;
        else if (cor_x_reg < -ONE_Q30)
            x_cl = -ONE_Q30;
        else
            x_cl = cor_x_reg;
        priority if (cor_y_reg > ONE_Q30)
            y_cl = ONE_Q30;
        else if (cor_y_reg < -ONE_Q30)
            y_cl = -ONE_Q30;
        else
            y_cl = cor_y_reg;
        unique case (quad_reg)
            2'd0:
            begin
                sn = 32'(y_cl);
                cs = 32'(x_cl);
            end
            2'd1:
            begin
                sn = 32'(x_cl);
                cs = 32'(-y_cl);
            end
            2'd2:
            begin
                sn = 32'(-y_cl);
                cs = 32'(-x_cl);
            end
            default:
            begin
                sn = 32'(-x_cl);
                cs = 32'(y_cl);
            end
        endcase
    end

    // shared multiplier operands
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] prod_next, acc_term, acc_next;

    always_comb
    begin
        unique case (cmd.sel)
            MS_CY_CP:  begin mul_a = cy_reg; mul_b = cp_reg; end
            MS_SY_CP:  begin mul_a = sy_reg; mul_b = cp_reg; end
            MS_CY_SP:  begin mul_a = cy_reg; mul_b = sp_reg; end
            MS_SY_SP:  begin mul_a = sy_reg; mul_b = sp_reg; end
            MS_RGT_MX: begin mul_a = 32'(rgt_reg[cmd.k]); mul_b = 32'(in_reg.move_x); end
            MS_UPV_MY: begin mul_a = 32'(upv_reg[cmd.k]); mul_b = 32'(in_reg.move_y); end
            MS_FWD_MZ: begin mul_a = 32'(fwd_reg[cmd.k]); mul_b = 32'(in_reg.move_z); end
            MS_CY_MX:  begin mul_a = cy_reg; mul_b = 32'(in_reg.move_x); end
            MS_SY_MZ:  begin mul_a = sy_reg; mul_b = 32'(in_reg.move_z); end
            MS_CY_MZ:  begin mul_a = cy_reg; mul_b = 32'(in_reg.move_z); end
            MS_SY_MX:  begin mul_a = sy_reg; mul_b = 32'(in_reg.move_x); end
            default:   begin mul_a = '0; mul_b = '0; end
        endcase
        prod_next = mul_a * mul_b;
        acc_term  = cmd.acc_sub ? -prod_reg : prod_reg;
        acc_next  = cmd.acc_clr ? acc_term : acc_reg + acc_term;
    end

    // position update with saturation
    logic signed [63:0] acc_rv, acc_rt;
    logic signed [33:0] delta, pos_sum;
    logic signed [31:0] pos_new;

    always_comb
    begin
        acc_rv = (acc_reg + (64'sd1 <<< (VEC_FRAC_BITS - 1))) >>> VEC_FRAC_BITS;
        acc_rt = (acc_reg + (64'sd1 <<< (TRIG_FRAC_BITS - 1))) >>> TRIG_FRAC_BITS;
        unique case (cmd.src)
            PS_ACC_VEC:  delta = 34'(acc_rv);
            PS_ACC_TRIG: delta = 34'(acc_rt);
            PS_MOVE_Y:   delta = 34'(in_reg.move_y);
            default:     delta = '0;
        endcase
        pos_sum = 34'(pos_reg[cmd.k]) + delta;
        priority if (pos_sum > SUM_MAX)
            pos_new = 32'(SUM_MAX);
        else if (pos_sum < SUM_MIN)
            pos_new = 32'(SUM_MIN);
        else
            pos_new = 32'(pos_sum);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
            in_reg <= in_item;
        if (cmd.mul_en)
            prod_reg <= prod_next;
        if (cmd.acc_en)
            acc_reg <= acc_next;
        if (cmd.cinit)
        begin
            cor_x_reg <= CX_INIT;
            cor_y_reg <= '0;
            cor_z_reg <= $signed({1'b0, z_scaled[31:0]});
            quad_reg  <= quad;
        end
        else if (cmd.citer)
        begin
            if (!cor_z_reg[32])
            begin
                cor_x_reg <= cor_x_reg - sh_y;
                cor_y_reg <= cor_y_reg + sh_x;
                cor_z_reg <= cor_z_reg - atan_i;
            end
            else
            begin
                cor_x_reg <= cor_x_reg + sh_y;
                cor_y_reg <= cor_y_reg - sh_x;
                cor_z_reg <= cor_z_reg + atan_i;
            end
        end
        if (cmd.out_load)
        begin
            out_reg.pos_x <= pos_reg[0];
            out_reg.pos_y <= pos_reg[1];
            out_reg.pos_z <= pos_reg[2];
            out_reg.fwd_x <= fwd_reg[0];
            out_reg.fwd_y <= fwd_reg[1];
            out_reg.fwd_z <= fwd_reg[2];
            out_reg.rgt_x <= rgt_reg[0];
            out_reg.rgt_y <= rgt_reg[1];
            out_reg.rgt_z <= rgt_reg[2];
            out_reg.upv_x <= upv_reg[0];
            out_reg.upv_y <= upv_reg[1];
            out_reg.upv_z <= upv_reg[2];
        end
    end

    // pose state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg <= 1'b0;
            yaw_reg    <= '0;
            pitch_reg  <= '0;
            sy_reg     <= '0;
            cy_reg     <= '0;
            sp_reg     <= '0;
            cp_reg     <= '0;
            for (int i = 0; i < 3; i++)
            begin
                pos_reg[i] <= '0;
                fwd_reg[i] <= '0;
                rgt_reg[i] <= '0;
                upv_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.load)
            begin
                loaded_reg <= 1'b1;
                pos_reg[0] <= start_x_reg;
                pos_reg[1] <= start_y_reg;
                pos_reg[2] <= start_z_reg;
                yaw_reg    <= start_yaw_red;
                pitch_reg  <= start_pitch_cl;
            end
            if (cmd.angle)
            begin
                yaw_reg   <= yaw_new;
                pitch_reg <= pitch_new;
            end
            if (cmd.cfin)
            begin
                if (cmd.csel_pitch)
                begin
                    sp_reg     <= sn;
                    cp_reg     <= cs;
                    fwd_reg[1] <= rnd_trig(33'(sn));
                    upv_reg[1] <= rnd_trig(33'(cs));
                    rgt_reg[0] <= rnd_trig(-33'(sy_reg));
                    rgt_reg[2] <= rnd_trig(33'(cy_reg));
                end
                else
                begin
                    sy_reg <= sn;
                    cy_reg <= cs;
                end
            end
            if (cmd.ax_wr)
            begin
                unique case (cmd.ax_idx)
                    2'd0: fwd_reg[0] <= rnd_prod(prod_reg);
                    2'd1: fwd_reg[2] <= rnd_prod(prod_reg);
                    2'd2: upv_reg[0] <= rnd_prod(-prod_reg);
                    default: upv_reg[2] <= rnd_prod(-prod_reg);
                endcase
            end
            if (cmd.pos_wr)
                pos_reg[cmd.k] <= pos_new;
        end
    end

    assign status.loaded = loaded_reg;
    assign status.mode   = in_reg.mode;
    assign status.moving = (in_reg.move_x != '0) || (in_reg.move_y != '0)
                           || (in_reg.move_z != '0);
    assign out_item      = out_reg;

endmodule

// ===== hdl/euler_camera_pose_update_core.sv =====
`timescale 1ns / 1ps

// Euler-angle fly camera pose keeper. Each request returns the full pose
// (position Q16.16, forward/right/up unit vectors Q1.14). One request is
// processed at a time; the input stalls from acceptance until the result
// is loaded into the output register, which may still wait while the next
// request is taken. The next request can be accepted at the first edge at
// which the result can be taken. A rotate takes two passes through the
// single sine/cosine CORDIC unit plus four products on the shared 32x32
// multiplier. The first request after reset also loads the start pose and
// builds the axes first. Start registers are read only at that first load.
module euler_camera_pose_update_core import ecp_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  cam_in_t     in_item,
    output logic        out_valid,
    input  logic        out_stall,
    output cam_out_t    out_item,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    ecp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    ecp_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_item   (in_item),
        .cmd       (cmd),
        .status    (status),
        .out_item  (out_item)
    );

endmodule

// ===== hdl/ecp_checker.sv =====
`timescale 1ns / 1ps

module ecp_checker import ecp_pkg::*; (
    input logic     clk,
    input logic     rst_n,
    input logic     in_valid,
    input logic     in_stall,
    input logic     out_valid,
    input logic     out_stall,
    input cam_out_t out_item
);

    // a waiting result is not dropped
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // one request at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second request taken while busy");

    // a new result only appears while the input side is busy
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without work");

    a_right_level: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_item.rgt_y == 16'sd0 &&
                      out_item.fwd_y >= -16'sd16384 && out_item.fwd_y <= 16'sd16384)
        else $error("axis out of range");

endmodule

bind euler_camera_pose_update_core ecp_checker u_chk (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import ecp_pkg::*;

    localparam longint FULL_TURN   = 46080;
    localparam longint QUARTER_TRN = 11520;
    localparam longint PITCH_LIM   = 11392;
    localparam int     VFB         = 14;
    localparam int     CYCLE_LIMIT = 600000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    cam_in_t     in_item;
    logic        out_valid;
    logic        out_stall;
    cam_out_t    out_item;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    euler_camera_pose_update_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // arctangent of 2^-i, Q30 radians
    const longint atan_tab [30] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
        64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002
    };

    // pose model
    logic [31:0] start_reg [5];
    longint      cam_pos [3];
    longint      cam_yaw;
    longint      cam_pitch;
    longint      fwd [3];
    longint      rgt [3];
    longint      upv [3];
    bit          pose_loaded;

    cam_in_t     pending_q [$];
    cam_out_t    pose_q [$];
    int          err_cnt;
    int          n_sent;
    int          n_got;
    int          n_mode [4];
    int          n_sat;
    int          src_idle;
    int          snk_stall;
    logic        hold_off;
    int          cycle_cnt;

    function automatic longint round_sh(input longint v, input int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    task automatic cordic_sincos(input longint a, output longint sn, output longint cs);
        longint r, q, z, x, y, dx, dy;
        r = a % FULL_TURN;
        if (r < 0)
            r += FULL_TURN;
        q = r / QUARTER_TRN;
        r -= q * QUARTER_TRN;
        z = (r * 9370165 + 32) >>> 6;
        x = 64'h26DD3B6A;
        y = 0;
        for (int i = 0; i < 30; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= atan_tab[i];
            end
            else
            begin
                x += dx; y -= dy; z += atan_tab[i];
            end
        end
        x = clip(x, -(longint'(1) <<< 30), longint'(1) <<< 30);
        y = clip(y, -(longint'(1) <<< 30), longint'(1) <<< 30);
        case (q)
            0:       begin sn = y;  cs = x;  end
            1:       begin sn = x;  cs = -y; end
            2:       begin sn = -y; cs = -x; end
            default: begin sn = -x; cs = y;  end
        endcase
    endtask

    task automatic rebuild_axes();
        longint sy, cy, sp, cp;
        cordic_sincos(cam_yaw, sy, cy);
        cordic_sincos(cam_pitch, sp, cp);
        fwd[0] = round_sh(cy * cp, 60 - VFB);
        fwd[1] = round_sh(sp, 30 - VFB);
        fwd[2] = round_sh(sy * cp, 60 - VFB);
        rgt[0] = round_sh(-sy, 30 - VFB);
        rgt[1] = 0;
        rgt[2] = round_sh(cy, 30 - VFB);
        upv[0] = round_sh(-(cy * sp), 60 - VFB);
        upv[1] = round_sh(cp, 30 - VFB);
        upv[2] = round_sh(-(sy * sp), 60 - VFB);
    endtask

    task automatic move_axis(input int k, input longint d);
        longint s;
        s = cam_pos[k] + d;
        if (s > 64'sh7FFFFFFF || s < -64'sh80000000)
            n_sat++;
        cam_pos[k] = clip(s, -64'sh80000000, 64'sh7FFFFFFF);
    endtask

    task automatic predict_pose(input cam_in_t req);
        longint mx, my, mz, sy, cy, t;
        cam_out_t r;
        mx = longint'(req.move_x);
        my = longint'(req.move_y);
        mz = longint'(req.move_z);
        if (!pose_loaded)
        begin
            for (int k = 0; k < 3; k++)
                cam_pos[k] = longint'($signed(start_reg[k]));
            cam_yaw = longint'(start_reg[3][15:0]) % FULL_TURN;
            cam_pitch = clip(longint'($signed(start_reg[4][14:0])), -PITCH_LIM, PITCH_LIM);
            rebuild_axes();
            pose_loaded = 1'b1;
        end
        n_mode[req.mode]++;
        if (req.mode == MODE_ROT)
        begin
            t = (cam_yaw + longint'(req.delta_yaw)) % FULL_TURN;
            cam_yaw = t < 0 ? t + FULL_TURN : t;
            cam_pitch = clip(cam_pitch + longint'(req.delta_pitch), -PITCH_LIM, PITCH_LIM);
            rebuild_axes();
        end
        else if (req.mode == MODE_FLY && (mx != 0 || my != 0 || mz != 0))
        begin
            for (int k = 0; k < 3; k++)
                move_axis(k, round_sh(rgt[k] * mx + upv[k] * my + fwd[k] * mz, VFB));
        end
        else if (req.mode == MODE_WALK && (mx != 0 || my != 0 || mz != 0))
        begin
            cordic_sincos(cam_yaw, sy, cy);
            move_axis(0, round_sh(cy * mx + sy * mz, 30));
            move_axis(1, my);
            move_axis(2, round_sh(cy * mz - sy * mx, 30));
        end
        r.pos_x = 32'(cam_pos[0]); r.pos_y = 32'(cam_pos[1]); r.pos_z = 32'(cam_pos[2]);
        r.fwd_x = 16'(fwd[0]); r.fwd_y = 16'(fwd[1]); r.fwd_z = 16'(fwd[2]);
        r.rgt_x = 16'(rgt[0]); r.rgt_y = 16'(rgt[1]); r.rgt_z = 16'(rgt[2]);
        r.upv_x = 16'(upv[0]); r.upv_y = 16'(upv[1]); r.upv_z = 16'(upv[2]);
        pose_q.push_back(r);
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_cnt++;
        end
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_item  <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_pose(in_item);
                n_sent++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_q.size() > 0 && $urandom_range(99) >= src_idle)
                begin
                    in_valid <= 1'b1;
                    in_item  <= pending_q.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                n_got++;
                if (pose_q.size() == 0)
                begin
                    $error("result with no pose expected");
                    err_cnt++;
                end
                else
                begin
                    cam_out_t e;
                    e = pose_q.pop_front();
                    check_field("pos_x", e.pos_x, out_item.pos_x);
                    check_field("pos_y", e.pos_y, out_item.pos_y);
                    check_field("pos_z", e.pos_z, out_item.pos_z);
                    check_field("fwd_x", e.fwd_x, out_item.fwd_x);
                    check_field("fwd_y", e.fwd_y, out_item.fwd_y);
                    check_field("fwd_z", e.fwd_z, out_item.fwd_z);
                    check_field("rgt_x", e.rgt_x, out_item.rgt_x);
                    check_field("rgt_y", e.rgt_y, out_item.rgt_y);
                    check_field("rgt_z", e.rgt_z, out_item.rgt_z);
                    check_field("upv_x", e.upv_x, out_item.upv_x);
                    check_field("upv_y", e.upv_y, out_item.upv_y);
                    check_field("upv_z", e.upv_z, out_item.upv_z);
                end
            end
            out_stall <= hold_off || ($urandom_range(99) < snk_stall);
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d poses outstanding", cycle_cnt, pose_q.size());
            $display("status: fail");
            $finish;
        end
    end

    function automatic cam_in_t mk_req(input logic [1:0] m, input int dy, input int dp,
                                        input int mx, input int my, input int mz);
        cam_in_t r;
        r.mode = m;
        r.delta_yaw = 16'(dy);
        r.delta_pitch = 16'(dp);
        r.move_x = 24'(mx);
        r.move_y = 24'(my);
        r.move_z = 24'(mz);
        return r;
    endfunction

    function automatic cam_in_t rand_req();
        cam_in_t r;
        int pick;
        logic [127:0] raw;
        pick = $urandom_range(99);
        r = '0;
        if (pick < 8)
        begin
            raw = {$urandom, $urandom, $urandom, $urandom};
            r = raw[$bits(cam_in_t)-1:0];
        end
        else if (pick < 40)
        begin
            r.mode = MODE_ROT;
            r.delta_yaw = $urandom_range(1) ? 16'($urandom)
                                            : 16'(int'($urandom_range(4000)) - 2000);
            r.delta_pitch = $urandom_range(1) ? 16'($urandom)
                                              : 16'(int'($urandom_range(4000)) - 2000);
            r.move_x = 24'($urandom);
        end
        else if (pick < 95)
        begin
            r.mode = $urandom_range(1) ? MODE_FLY : MODE_WALK;
            r.move_x = 24'($urandom);
            r.move_y = 24'($urandom);
            r.move_z = 24'($urandom);
            r.delta_yaw = 16'($urandom);
            if ($urandom_range(9) == 0)
                r.move_y = '0;
            if ($urandom_range(11) == 0)
                {r.move_x, r.move_y, r.move_z} = '0;
        end
        else
        begin
            r.mode = MODE_SPARE;
            r.move_z = 24'($urandom);
        end
        return r;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_START_YAW:   start_reg[idx] = {16'd0, val[15:0]};
            CFG_START_PITCH: start_reg[idx] = {17'd0, val[14:0]};
            default:         start_reg[idx] = val;
        endcase
    endtask

    task automatic drain();
        // sampled at the falling edge, once the driver's updates have settled
        while (pending_q.size() != 0 || in_valid || pose_q.size() != 0)
            @(negedge clk);
        repeat (100) @(posedge clk);
    endtask

    initial
    begin
        int ph;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        hold_off = 1'b0;
        src_idle = 0;
        snk_stall = 0;
        cycle_cnt = 0;
        err_cnt = 0;
        n_sent = 0;
        n_got = 0;
        n_sat = 0;
        n_mode = '{0, 0, 0, 0};
        pose_loaded = 1'b0;
        for (int i = 0; i < 5; i++)
            start_reg[i] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // start pose near the extremes; yaw above a full turn, pitch past the clamp
        write_reg(CFG_START_X, 32'h7FFF0000);
        write_reg(CFG_START_Y, 32'h80000000);
        write_reg(CFG_START_Z, 32'hFFFFFFFF);
        write_reg(CFG_START_YAW, 32'hFFFFFFFF);
        write_reg(CFG_START_PITCH, 32'h00004000);

        pending_q.push_back(mk_req(MODE_FLY, 0, 0, 8388607, -8388608, 0));
        pending_q.push_back(mk_req(MODE_FLY, 0, 0, 8388607, -8388608, 8388607));
        pending_q.push_back(mk_req(MODE_WALK, 0, 0, -8388608, 8388607, -8388608));
        pending_q.push_back(mk_req(MODE_WALK, 0, 0, 0, 0, 0));
        pending_q.push_back(mk_req(MODE_FLY, 0, 0, 0, 0, 0));
        pending_q.push_back(mk_req(MODE_SPARE, -1, -1, -1, -1, -1));
        pending_q.push_back(mk_req(MODE_ROT, 23039, 23039, 0, 0, 0));
        pending_q.push_back(mk_req(MODE_ROT, -23040, -23040, 0, 0, 0));
        pending_q.push_back(mk_req(MODE_ROT, 32767, -32768, 0, 0, 0));
        pending_q.push_back(mk_req(MODE_ROT, -32768, 32767, 0, 0, 0));
        pending_q.push_back(mk_req(MODE_ROT, 11520, 0, 0, 0, 0));
        pending_q.push_back(mk_req(MODE_ROT, 11520, 11392, 0, 0, 0));
        pending_q.push_back(mk_req(MODE_ROT, 11520, -22784, 0, 0, 0));
        pending_q.push_back(mk_req(MODE_ROT, -11521, 11392, 0, 0, 0));
        pending_q.push_back(mk_req(MODE_FLY, 0, 0, 65536, 65536, 65536));
        pending_q.push_back(mk_req(MODE_WALK, 0, 0, 65536, -65536, 65536));
        pending_q.push_back(mk_req(MODE_ROT, 0, 0, 0, 0, 0));
        pending_q.push_back(mk_req(MODE_FLY, 0, 0, -1, 0, 1));
        drain();

        // start registers only matter at the first load; later writes must not disturb the pose
        for (ph = 0; ph < 4; ph++)
        begin
            write_reg(CFG_START_X, ph[0] ? 32'h80000000 : $urandom);
            write_reg(CFG_START_Y, ph[1] ? 32'h7FFFFFFF : $urandom);
            write_reg(CFG_START_Z, $urandom);
            write_reg(CFG_START_YAW, ph[0] ? 32'd46079 : $urandom);
            write_reg(CFG_START_PITCH, ph[1] ? 32'h00007FFF : $urandom);
            src_idle  <= (ph == 1) ? 58 : (ph == 3) ? 18 : 0;
            snk_stall <= (ph == 2) ? 58 : (ph == 3) ? 18 : 0;
            for (int i = 0; i < 95; i++)
                pending_q.push_back(rand_req());
            if (ph == 0)
            begin
                // receiver holds off while requests keep coming
                hold_off <= 1'b1;
                repeat (600) @(posedge clk);
                hold_off <= 1'b0;
            end
            drain();
        end

        $display("covered %0d requests (rotate %0d, fly %0d, walk %0d, unused %0d), %0d results",
                 n_sent, n_mode[0], n_mode[1], n_mode[2], n_mode[3], n_got);
        $display("position saturated %0d times; idle and stall phases 0/58/18 percent", n_sat);
        if (pose_q.size() != 0)
        begin
            $error("%0d poses never returned", pose_q.size());
            err_cnt++;
        end
        if (err_cnt == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
